// ===== rtl/session_key_validity_table_defines.svh =====
// ----------------------------------------------------------------------------
// Session key validity table: assertion macros
// Shared helpers for concurrent checks, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef SESSION_KEY_VALIDITY_TABLE_DEFINES_SVH
`define SESSION_KEY_VALIDITY_TABLE_DEFINES_SVH

// Same-cycle implication.
`define SKVT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication.
`define SKVT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Session key validity table package
// Payload types, command and status codes, register indexes.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int TIME_BITS      = 48;
   localparam int USER_BITS      = 16;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam int SLOTS_DEFAULT  = 16;

   localparam logic [31:0]         KEY_DURATION_RESET  = 32'd900000;
   localparam logic [15:0]         MAX_USE_COUNT_RESET = 16'd1000;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX         = '1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_DURATION  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_USE_COUNT = 1'b1;

   typedef enum logic [1:0] {
      CMD_SET_KEYS   = 2'd0,
      CMD_GET_STATUS = 2'd1,
      CMD_GET_KEY    = 2'd2,
      CMD_INCREMENT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_COMM_FAIL  = 2'd1,
      ST_NOT_INIT   = 2'd2,
      ST_TABLE_FULL = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                command;
      logic [USER_BITS-1:0]   user_number;
      logic [TIME_BITS-1:0]   now_time;
   } req_type;

   typedef struct packed {
      status_type  key_status;
      logic [3:0]  slot_index;
      logic        key_available;
   } rsp_type;

   // Contents of the slot matched by the current user, plus search flags.
   typedef struct packed {
      logic                  hit;
      logic                  free_found;
      logic                  failed;
      logic [COUNT_BITS-1:0] use_count;
      logic [TIME_BITS-1:0]  expiry;
   } lookup_type;

   // Slot update; claim marks a new slot used for the request's user.
   typedef struct packed {
      logic                  we;
      logic                  claim;
      logic                  failed;
      logic [COUNT_BITS-1:0] use_count;
      logic [TIME_BITS-1:0]  expiry;
   } slot_wr_type;

endpackage

// ===== rtl/skvt_slot_table.sv =====
// ----------------------------------------------------------------------------
// Slot table
// Per-slot storage with parallel user match, free-slot search and update.
// ----------------------------------------------------------------------------
`include "session_key_validity_table_defines.svh"

module skvt_slot_table #(
   parameter int SLOTS    = skvt_pkg::SLOTS_DEFAULT,
   parameter int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [skvt_pkg::USER_BITS-1:0]   lookup_user,
   input  skvt_pkg::slot_wr_type            wr,
   input  logic [IDX_BITS-1:0]              wr_idx,
   output skvt_pkg::lookup_type             lookup,
   output logic [IDX_BITS-1:0]              hit_idx,
   output logic [IDX_BITS-1:0]              free_idx
);

   logic                                used_ff   [SLOTS];
   logic [skvt_pkg::USER_BITS-1:0]      user_ff   [SLOTS];
   logic                                failed_ff [SLOTS];
   logic [skvt_pkg::COUNT_BITS-1:0]     count_ff  [SLOTS];
   logic [skvt_pkg::TIME_BITS-1:0]      expiry_ff [SLOTS];

   logic [SLOTS-1:0] hit_vec;

   // A user sits in at most one slot, so the hit index and fields are AND-OR.
   always_comb begin
      hit_idx          = '0;
      free_idx         = '0;
      lookup.hit       = 1'b0;
      lookup.free_found = 1'b0;
      lookup.failed    = 1'b0;
      lookup.use_count = '0;
      lookup.expiry    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_vec[i] = used_ff[i] && (user_ff[i] == lookup_user);
         if (hit_vec[i]) begin
            hit_idx          = hit_idx | IDX_BITS'(i);
            lookup.failed    = lookup.failed | failed_ff[i];
            lookup.use_count = lookup.use_count | count_ff[i];
            lookup.expiry    = lookup.expiry | expiry_ff[i];
         end
      end
      lookup.hit = |hit_vec;
      // lowest free slot wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx          = IDX_BITS'(i);
            lookup.free_found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (reset) begin
            used_ff[i] <= 1'b0;
         end else if (wr.we && wr.claim && (wr_idx == IDX_BITS'(i))) begin
            used_ff[i] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (wr.we && (wr_idx == IDX_BITS'(i))) begin
            if (wr.claim) begin
               user_ff[i] <= lookup_user;
            end
            failed_ff[i] <= wr.failed;
            count_ff[i]  <= wr.use_count;
            expiry_ff[i] <= wr.expiry;
         end
      end
   end

   `SKVT_ASSERT_IMP(a_single_match, 1'b1, $onehot0(hit_vec))
   `SKVT_ASSERT_IMP(a_claim_free, wr.we && wr.claim, !lookup.hit && lookup.free_found)
   `SKVT_ASSERT_NXT(a_claim_sets_used, wr.we && wr.claim, used_ff[$past(wr_idx)])

endmodule

// ===== rtl/skvt_eval.sv =====
// ----------------------------------------------------------------------------
// Command evaluation
// Status decision and slot update for one request, purely combinational.
// ----------------------------------------------------------------------------
module skvt_eval #(
   parameter int IDX_BITS = 4
) (
   input  skvt_pkg::req_type                 req,
   input  skvt_pkg::lookup_type              lookup,
   input  logic [IDX_BITS-1:0]               hit_idx,
   input  logic [IDX_BITS-1:0]               free_idx,
   input  logic [31:0]                       key_duration,
   input  logic [15:0]                       max_use_count,
   output skvt_pkg::rsp_type                 rsp,
   output skvt_pkg::slot_wr_type             wr,
   output logic [IDX_BITS-1:0]               wr_idx
);

   localparam int SUM_BITS = skvt_pkg::TIME_BITS + 1;

   logic [SUM_BITS-1:0]                sum;
   logic [skvt_pkg::TIME_BITS-1:0]     expiry_new;
   logic                               expired;
   logic [skvt_pkg::COUNT_BITS-1:0]    count_inc;
   logic                               slot_valid;
   logic [IDX_BITS+3:0]                idx_wide;

   always_comb begin
      sum        = SUM_BITS'(req.now_time) + SUM_BITS'(key_duration);
      expiry_new = sum[SUM_BITS-1] ? '1 : sum[skvt_pkg::TIME_BITS-1:0];
      expired    = req.now_time >= lookup.expiry;
      count_inc  = (lookup.use_count == skvt_pkg::COUNT_MAX) ?
                   lookup.use_count : lookup.use_count + 1'b1;

      rsp.key_status    = skvt_pkg::ST_NOT_INIT;
      rsp.key_available = 1'b0;
      slot_valid        = lookup.hit;
      wr_idx            = hit_idx;
      wr.we             = 1'b0;
      wr.claim          = 1'b0;
      wr.failed         = lookup.failed;
      wr.use_count      = lookup.use_count;
      wr.expiry         = lookup.expiry;

      case (req.command) inside
         skvt_pkg::CMD_SET_KEYS: begin
            if (lookup.hit || lookup.free_found) begin
               wr_idx         = lookup.hit ? hit_idx : free_idx;
               slot_valid     = 1'b1;
               wr.we          = 1'b1;
               wr.claim       = !lookup.hit;
               wr.failed      = 1'b0;
               wr.use_count   = '0;
               wr.expiry      = expiry_new;
               rsp.key_status = skvt_pkg::ST_OK;
            end else begin
               rsp.key_status = skvt_pkg::ST_TABLE_FULL;
            end
         end
         skvt_pkg::CMD_GET_STATUS, skvt_pkg::CMD_GET_KEY: begin
            if (lookup.hit) begin
               if (lookup.failed || expired) begin
                  rsp.key_status = skvt_pkg::ST_COMM_FAIL;
               end else begin
                  rsp.key_status    = skvt_pkg::ST_OK;
                  rsp.key_available = (req.command == skvt_pkg::CMD_GET_KEY);
               end
            end
         end
         default: begin
            // increment: latch failure on expiry or on reaching the limit
            if (lookup.hit) begin
               if (lookup.failed) begin
                  rsp.key_status = skvt_pkg::ST_COMM_FAIL;
               end else if (expired) begin
                  wr.we          = 1'b1;
                  wr.failed      = 1'b1;
                  rsp.key_status = skvt_pkg::ST_COMM_FAIL;
               end else begin
                  wr.we        = 1'b1;
                  wr.use_count = count_inc;
                  wr.failed    = count_inc >= max_use_count;
                  rsp.key_status = wr.failed ? skvt_pkg::ST_COMM_FAIL : skvt_pkg::ST_OK;
               end
            end
         end
      endcase

      idx_wide       = {4'b0000, wr_idx};
      rsp.slot_index = slot_valid ? idx_wide[3:0] : 4'b0000;
   end

endmodule

// ===== rtl/session_key_validity_table.sv =====
// ----------------------------------------------------------------------------
// Session key validity table
// Per-user session key slots: set, query, and count-and-expire checks.
// ----------------------------------------------------------------------------
//
//   channel  ports                          direction  transfer when
//   req      req_valid/req_ready/req_payload  in       req_valid & req_ready
//   rsp      rsp_valid/rsp_ready/rsp_payload  out      rsp_valid & rsp_ready
//   csr      csr_write_en/csr_index/csr_wdata in       csr_write_en
//
// One request per cycle sustained while rsp_ready holds high; a request
// passes through the request register, then the response register.
// Match, status compare and expiry add settle between those registers, and
// the slot update lands as rsp_ff loads, so the next request sees it.
// Synchronous reset empties every slot and restores the register defaults.
// A stalled response holds; req_ready drops while the request register is full and cannot advance.
//
`include "session_key_validity_table_defines.svh"

module session_key_validity_table #(
   parameter int SLOTS = skvt_pkg::SLOTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  skvt_pkg::req_type                     req_payload,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output skvt_pkg::rsp_type                     rsp_payload,
   // register writes
   input  logic                                  csr_write_en,
   input  logic [skvt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [skvt_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // request stage
   logic                     req_valid_ff;
   skvt_pkg::req_type        req_ff;
   // response stage
   logic                     rsp_valid_ff;
   skvt_pkg::rsp_type        rsp_ff;
   // configuration
   logic [31:0]              key_duration_ff;
   logic [15:0]              max_use_count_ff;

   logic                     advance;
   skvt_pkg::lookup_type     lookup;
   logic [IDX_BITS-1:0]      hit_idx;
   logic [IDX_BITS-1:0]      free_idx;
   skvt_pkg::rsp_type        rsp_in;
   skvt_pkg::slot_wr_type    eval_wr;
   skvt_pkg::slot_wr_type    table_wr;
   logic [IDX_BITS-1:0]      wr_idx;
   logic                     rsp_is_ok;
   logic                     rsp_is_full;

   // The held request moves on whenever the response register is free or
   // being drained this cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Slot writes only commit when the request actually completes.
   always_comb begin
      table_wr    = eval_wr;
      table_wr.we = eval_wr.we && advance;
   end

   skvt_slot_table #(
      .SLOTS    (SLOTS),
      .IDX_BITS (IDX_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .lookup_user (req_ff.user_number),
      .wr          (table_wr),
      .wr_idx      (wr_idx),
      .lookup      (lookup),
      .hit_idx     (hit_idx),
      .free_idx    (free_idx)
   );

   skvt_eval #(
      .IDX_BITS (IDX_BITS)
   ) u_eval (
      .req           (req_ff),
      .lookup        (lookup),
      .hit_idx       (hit_idx),
      .free_idx      (free_idx),
      .key_duration  (key_duration_ff),
      .max_use_count (max_use_count_ff),
      .rsp           (rsp_in),
      .wr            (eval_wr),
      .wr_idx        (wr_idx)
   );

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Configuration registers; the user must write them only while idle, the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_duration_ff  <= skvt_pkg::KEY_DURATION_RESET;
         max_use_count_ff <= skvt_pkg::MAX_USE_COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            skvt_pkg::REG_KEY_DURATION:  key_duration_ff  <= csr_wdata;
            skvt_pkg::REG_MAX_USE_COUNT: max_use_count_ff <= csr_wdata[15:0];
         endcase
      end
   end

   assign rsp_is_ok   = (rsp_payload.key_status == skvt_pkg::ST_OK);
   assign rsp_is_full = (rsp_payload.key_status == skvt_pkg::ST_TABLE_FULL);

   `SKVT_ASSERT_NXT(a_advance_gives_rsp, advance, rsp_valid)
   `SKVT_ASSERT_IMP(a_avail_only_ok, rsp_valid && rsp_payload.key_available, rsp_is_ok)
   `SKVT_ASSERT_IMP(a_full_no_slot, rsp_valid && rsp_is_full, rsp_payload.slot_index == 4'b0000)

endmodule
